// File: src/swaf_pkg.sv
// Package: constants, item kinds and pipeline types of the anagram finder.
`timescale 1ns / 1ps
`default_nettype none
package swaf_pkg;

  localparam int ALPHABET   = 26;
  localparam int WINDOW_MAX = 1024;

  localparam int KIND_W   = 2;
  localparam int LETTER_W = 5;
  localparam int POS_W    = 32;

  localparam int BAL_AW  = $clog2(ALPHABET);
  localparam int HIST_AW = $clog2(WINDOW_MAX);
  localparam int PLEN_W  = $clog2(WINDOW_MAX + 1);
  // balance spans -WINDOW_MAX..+WINDOW_MAX, counts are kept modulo 2**BAL_W
  localparam int BAL_W   = $clog2(WINDOW_MAX) + 2;
  localparam int UB_W    = $clog2(ALPHABET + 1);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1) + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_TEXT    = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [BAL_AW-1:0] letter;
    logic              upd;     // text letter touches the counts
    logic              dec_en;  // a letter leaves the window
    logic              full;
    logic [POS_W-1:0]  start;
  } swaf_op_t;

  typedef struct packed {
    logic             match;
    logic [POS_W-1:0] window_start;
  } swaf_res_t;

endpackage
`default_nettype wire

// File: src/swaf_in_if.sv
// Interface: input item channel of the anagram finder.
`timescale 1ns / 1ps
`default_nettype none
interface swaf_in_if;
  import swaf_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [LETTER_W-1:0] letter;

  modport source (output valid, kind, letter, input ready);
  modport sink   (input valid, kind, letter, output ready);
endinterface
`default_nettype wire

// File: src/swaf_out_if.sv
// Interface: result item channel of the anagram finder.
`timescale 1ns / 1ps
`default_nettype none
interface swaf_out_if;
  import swaf_pkg::*;

  logic             valid;
  logic             ready;
  logic             match;
  logic [POS_W-1:0] window_start;

  modport source (output valid, match, window_start, input ready);
  modport sink   (input valid, match, window_start, output ready);
endinterface
`default_nettype wire

// File: src/sliding_window_anagram_finder.sv
// Streaming sliding-window anagram finder over letter codes.
// Usage:
//   in_i carries items: kind clear starts a new job, kind pattern loads one
//   pattern letter, kind text streams one text letter. Each accepted text
//   item with a letter code below 26 gives one result item on out_o: a match
//   flag and the text position where the current window starts. Other items
//   give no result.
//   Throughput is one item per cycle while out_o keeps up. Accepting an item
//   reads the window history into stage s1; stage s1 reads the two count
//   memories into stage s2, and stage s2 writes the update back and queues
//   the result, which is valid on out_o from then on. The
//   next item sees that update through forwarding.
//   Results wait in a four-item output queue; in_i.ready drops while the
//   queued results plus the items in the two pipeline stages reach four, so
//   a stalled receiver stops the input once queue and pipeline hold four.
//   Reset (and a clear item) empties the counts through per-entry valid
//   bits at once; no clearing pass is needed and the block is ready in the
//   first cycle after reset. The window history needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_anagram_finder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  swaf_in_if.sink         in_i,
  swaf_out_if.source      out_o
);
  import swaf_pkg::*;

  // control state, updated at acceptance
  logic [PLEN_W-1:0]  plen_q, plen_d;
  logic [PLEN_W-1:0]  held_q, held_d;
  logic [HIST_AW-1:0] wp_q, wp_d;
  logic [POS_W-1:0]   tp_q, tp_d;

  logic               accept;
  logic               issue;
  logic               letter_ok;
  swaf_op_t           op_d;
  logic               hist_we;
  logic [HIST_AW-1:0] old_idx;

  // window history memory
  logic [BAL_AW-1:0]  hist_mem [WINDOW_MAX];
  logic [BAL_AW-1:0]  hist_rd_q;

  // pipeline
  logic               s1_v_q, s2_v_q;
  swaf_op_t           s1_op_q, s2_op_q;
  logic [BAL_AW-1:0]  s2_old_q;

  // count memories: arrivals (a) and departures (b); balance = a - b
  logic [BAL_W-1:0]   a_mem [ALPHABET];
  logic [BAL_W-1:0]   b_mem [ALPHABET];
  logic [ALPHABET-1:0] a_vld_q, b_vld_q;
  logic [BAL_W-1:0]   a_rd0_q, a_rd1_q, b_rd0_q, b_rd1_q;
  logic               a_v0_q, a_v1_q, b_v0_q, b_v1_q;

  logic               a_we, b_we, clr;
  logic [BAL_AW-1:0]  a_wa, b_wa;
  logic [BAL_W-1:0]   a_wd, b_wd;

  // write-back forwarding
  logic               fw_clr_q, fw_a_we_q, fw_b_we_q;
  logic [BAL_AW-1:0]  fw_a_addr_q, fw_b_addr_q;
  logic [BAL_W-1:0]   fw_a_data_q, fw_b_data_q;

  logic [BAL_W-1:0]   a0, a1, b0, b1, bal_c, bal_o;
  logic [UB_W-1:0]    ub_q, ub_d;
  logic               push;
  swaf_res_t          res;

  // output queue
  swaf_res_t          oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0]   oq_wp_q, oq_rp_q;
  logic [OQ_CW-1:0]   oq_cnt_q, oq_cnt_d;
  logic [OQ_CW-1:0]   busy;
  logic               pop;

  // ---------------------------------------------------------------- accept
  assign busy     = oq_cnt_q + OQ_CW'(s1_v_q) + OQ_CW'(s2_v_q);
  assign in_i.ready = (busy < OQ_CW'(OQ_DEPTH));
  assign accept   = in_i.valid && in_i.ready;
  assign letter_ok = (int'(in_i.letter) < ALPHABET);
  assign old_idx  = wp_q - HIST_AW'(plen_q);

  always_comb begin
    plen_d      = plen_q;
    held_d      = held_q;
    wp_d        = wp_q;
    tp_d        = tp_q;
    issue       = 1'b0;
    hist_we     = 1'b0;
    op_d.kind   = KIND_CLEAR;
    op_d.letter = BAL_AW'(in_i.letter);
    op_d.upd    = 1'b0;
    op_d.dec_en = 1'b0;
    op_d.full   = 1'b0;
    op_d.start  = '0;
    if (accept) begin
      case (in_i.kind)
        KIND_CLEAR: begin
          plen_d = '0;
          held_d = '0;
          wp_d   = '0;
          tp_d   = '0;
          issue  = 1'b1;
        end
        KIND_PATTERN: begin
          // pattern letters after the first text letter or beyond capacity drop
          if (letter_ok && tp_q == '0 && plen_q < PLEN_W'(WINDOW_MAX)) begin
            plen_d    = plen_q + 1'b1;
            issue     = 1'b1;
            op_d.kind = KIND_PATTERN;
          end
        end
        KIND_TEXT: begin
          if (letter_ok) begin
            issue     = 1'b1;
            op_d.kind = KIND_TEXT;
            if (plen_q != '0) begin
              op_d.upd = 1'b1;
              hist_we  = 1'b1;
              wp_d     = wp_q + 1'b1;
              if (held_q < plen_q) begin
                held_d = held_q + 1'b1;
              end else begin
                op_d.dec_en = 1'b1;
              end
            end
            if (tp_q != '1) begin
              tp_d = tp_q + 1'b1;
            end
            op_d.full = (held_d == plen_q);
            if (op_d.full) begin
              op_d.start = tp_d - POS_W'(plen_q);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
      held_q <= '0;
      wp_q   <= '0;
      tp_q   <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      plen_q <= plen_d;
      held_q <= held_d;
      wp_q   <= wp_d;
      tp_q   <= tp_d;
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  // read-first: with a full 1024-letter window the leaving letter sits at wp
  always_ff @(posedge clk_i) begin
    hist_rd_q <= hist_mem[old_idx];
    if (hist_we) begin
      hist_mem[wp_q] <= BAL_AW'(in_i.letter);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q  <= op_d;
    s2_op_q  <= s1_op_q;
    s2_old_q <= hist_rd_q;
  end

  // ---------------------------------------------------------- count memories
  always_ff @(posedge clk_i) begin
    a_rd0_q <= a_mem[s1_op_q.letter];
    a_rd1_q <= a_mem[hist_rd_q];
    b_rd0_q <= b_mem[s1_op_q.letter];
    b_rd1_q <= b_mem[hist_rd_q];
    a_v0_q  <= a_vld_q[s1_op_q.letter];
    a_v1_q  <= a_vld_q[hist_rd_q];
    b_v0_q  <= b_vld_q[s1_op_q.letter];
    b_v1_q  <= b_vld_q[hist_rd_q];
    if (a_we) begin
      a_mem[a_wa] <= a_wd;
    end
    if (b_we) begin
      b_mem[b_wa] <= b_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= '0;
      b_vld_q   <= '0;
      fw_clr_q  <= 1'b0;
      fw_a_we_q <= 1'b0;
      fw_b_we_q <= 1'b0;
      ub_q      <= '0;
    end else begin
      if (clr) begin
        a_vld_q <= '0;
        b_vld_q <= '0;
      end else begin
        if (a_we) a_vld_q[a_wa] <= 1'b1;
        if (b_we) b_vld_q[b_wa] <= 1'b1;
      end
      fw_clr_q  <= clr;
      fw_a_we_q <= a_we;
      fw_b_we_q <= b_we;
      ub_q      <= ub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fw_a_addr_q <= a_wa;
    fw_a_data_q <= a_wd;
    fw_b_addr_q <= b_wa;
    fw_b_data_q <= b_wd;
  end

  // read data corrected for the write (or clear) of the item just ahead
  always_comb begin
    a0 = a_v0_q ? a_rd0_q : '0;
    a1 = a_v1_q ? a_rd1_q : '0;
    b0 = b_v0_q ? b_rd0_q : '0;
    b1 = b_v1_q ? b_rd1_q : '0;
    if (fw_clr_q) begin
      a0 = '0;
      a1 = '0;
      b0 = '0;
      b1 = '0;
    end else begin
      if (fw_a_we_q && fw_a_addr_q == s2_op_q.letter) a0 = fw_a_data_q;
      if (fw_a_we_q && fw_a_addr_q == s2_old_q)       a1 = fw_a_data_q;
      if (fw_b_we_q && fw_b_addr_q == s2_op_q.letter) b0 = fw_b_data_q;
      if (fw_b_we_q && fw_b_addr_q == s2_old_q)       b1 = fw_b_data_q;
    end
  end

  assign bal_c = a0 - b0;
  assign bal_o = a1 - b1;

  always_comb begin
    a_we = 1'b0;
    a_wa = s2_op_q.letter;
    a_wd = a0;
    b_we = 1'b0;
    b_wa = s2_old_q;
    b_wd = b1;
    clr  = 1'b0;
    push = 1'b0;
    ub_d = ub_q;
    if (s2_v_q) begin
      case (s2_op_q.kind)
        KIND_CLEAR: begin
          clr  = 1'b1;
          ub_d = '0;
        end
        KIND_PATTERN: begin
          a_we = 1'b1;
          a_wd = a0 - 1'b1;
          if (bal_c == '0) begin
            ub_d = ub_q + 1'b1;
          end else if (bal_c == BAL_W'(1)) begin
            ub_d = ub_q - 1'b1;
          end
        end
        KIND_TEXT: begin
          push = 1'b1;
          if (s2_op_q.upd) begin
            a_we = 1'b1;
            a_wd = a0 + 1'b1;
            if (s2_op_q.dec_en) begin
              b_we = 1'b1;
              b_wd = b1 + 1'b1;
            end
            // same letter entering and leaving: balance unchanged
            if (!(s2_op_q.dec_en && s2_old_q == s2_op_q.letter)) begin
              if (bal_c == '0) begin
                ub_d = ub_d + 1'b1;
              end else if (bal_c == '1) begin
                ub_d = ub_d - 1'b1;
              end
              if (s2_op_q.dec_en) begin
                if (bal_o == '0) begin
                  ub_d = ub_d + 1'b1;
                end else if (bal_o == BAL_W'(1)) begin
                  ub_d = ub_d - 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign res.match        = s2_op_q.full && (ub_d == '0);
  assign res.window_start = s2_op_q.start;

  // ------------------------------------------------------------ output queue
  assign pop = out_o.valid && out_o.ready;

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (push && !pop) begin
      oq_cnt_d = oq_cnt_q + 1'b1;
    end else if (pop && !push) begin
      oq_cnt_d = oq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= '0;
      oq_rp_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (push) oq_wp_q <= oq_wp_q + 1'b1;
      if (pop)  oq_rp_q <= oq_rp_q + 1'b1;
      oq_cnt_q <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      oq_mem[oq_wp_q] <= res;
    end
  end

  assign out_o.valid        = (oq_cnt_q != '0);
  assign out_o.match        = oq_mem[oq_rp_q].match;
  assign out_o.window_start = oq_mem[oq_rp_q].window_start;

endmodule
`default_nettype wire

// File: src/swaf_checker.sv
// Checker: port-level assertions of the anagram finder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module swaf_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic [swaf_pkg::KIND_W-1:0] in_kind_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic                       out_match_i,
  input wire logic [swaf_pkg::POS_W-1:0] out_start_i
);
  import swaf_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_match_i) && $stable(out_start_i))
    else $error("result changed while stalled");

  // an empty queue only fills from an earlier accepted text item
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |->
      $past(in_valid_i && in_ready_i && in_kind_i == KIND_TEXT, 3))
    else $error("result without a text item");

  // backpressure only arises from a waiting result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no pending result");

endmodule

bind sliding_window_anagram_finder swaf_checker u_swaf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_match_i (out_o.match),
  .out_start_i (out_o.window_start)
);
`default_nettype wire

// File: tb/sv/swaf_tb_pkg.sv
// Scoreboard package: expected-result predictor and checker for the anagram finder bench.
`timescale 1ns / 1ps
package swaf_tb_pkg;
  import swaf_pkg::*;

  // kind 3 has no meaning to the block and must be dropped
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;

  class anagram_scoreboard;
    // per letter: text window count minus pattern count
    int                  count_diff [ALPHABET];
    int unsigned         mismatched_letters;
    int unsigned         pat_len;
    bit [POS_W-1:0]      text_pos;
    int unsigned         in_window;
    int unsigned         hist_wr;
    logic [LETTER_W-1:0] recent_text [WINDOW_MAX];
    swaf_res_t           expected_hits [$];
    int unsigned         failures;
    int unsigned         items_seen;
    int unsigned         results_seen;
    int unsigned         matches_seen;

    function new();
      clear_job();
    endfunction

    function void clear_job();
      foreach (count_diff[i]) count_diff[i] = 0;
      mismatched_letters = 0;
      pat_len            = 0;
      text_pos           = '0;
      in_window          = 0;
      hist_wr            = 0;
    endfunction

    function void shift_count(int unsigned c, int delta);
      int prev;
      prev          = count_diff[c];
      count_diff[c] = prev + delta;
      if (prev == 0 && count_diff[c] != 0) mismatched_letters++;
      else if (prev != 0 && count_diff[c] == 0) mismatched_letters--;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // accepted input item: update the predicted state, queue the result it gives
    function void take_item(logic [KIND_W-1:0] kind, logic [LETTER_W-1:0] letter);
      swaf_res_t res;
      bit        full;
      items_seen++;
      if (kind == KIND_CLEAR) begin
        clear_job();
        return;
      end
      if (kind == KIND_UNUSED || letter >= ALPHABET) return;
      if (kind == KIND_PATTERN) begin
        // pattern is frozen once text has started, and capped at the window size
        if (text_pos == 0 && pat_len < WINDOW_MAX) begin
          shift_count(letter, -1);
          pat_len++;
        end
        return;
      end
      if (pat_len > 0) begin
        shift_count(letter, 1);
        if (in_window < pat_len) begin
          in_window++;
        end else begin
          shift_count(recent_text[(hist_wr + WINDOW_MAX - pat_len) % WINDOW_MAX], -1);
        end
        recent_text[hist_wr] = letter;
        hist_wr              = (hist_wr + 1) % WINDOW_MAX;
      end
      if (text_pos != '1) text_pos++;
      full               = (in_window == pat_len);
      res.match          = full && (mismatched_letters == 0);
      res.window_start   = full ? text_pos - POS_W'(pat_len) : '0;
      expected_hits.insert(expected_hits.size(), res);
    endfunction

    function void check_result(logic match, logic [POS_W-1:0] window_start);
      swaf_res_t want;
      results_seen++;
      if (match === 1'b1) matches_seen++;
      if (expected_hits.size() == 0) begin
        note_failure($sformatf("unexpected result match=%0b window_start=%0d",
                               match, window_start));
        return;
      end
      want = expected_hits.pop_front();
      if (want.match !== match || want.window_start !== window_start)
        note_failure($sformatf("match exp %0b got %0b, window_start exp %0d got %0d",
                               want.match, match, want.window_start, window_start));
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction

    function void report_leftover();
      if (expected_hits.size() != 0)
        note_failure($sformatf("%0d expected results never arrived", expected_hits.size()));
    endfunction
  endclass

endpackage

// File: tb/sv/sliding_window_anagram_finder_tb.sv
// Testbench top: random and directed item streams against the anagram finder, self-checking.
`timescale 1ns / 1ps
module sliding_window_anagram_finder_tb;
  import swaf_pkg::*;
  import swaf_tb_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int STIM_TARGET  = 1750;
  localparam int NOISE_PCT    = 5;
  localparam int BIG_PLEN     = 150;
  localparam int BIG_REPS     = 7;

  typedef logic [LETTER_W-1:0] letter_q_t [$];

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [LETTER_W-1:0] letter;
  } swaf_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  swaf_in_if  in_if ();
  swaf_out_if out_if ();

  sliding_window_anagram_finder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  anagram_scoreboard sb;
  swaf_item_t        stim_q [$];
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  int                quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // both handshakes are observed here; the watchdog trips on a long silence
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.take_item(in_if.kind, in_if.letter);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.match, out_if.window_start);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic void add_item(logic [KIND_W-1:0] kind, logic [LETTER_W-1:0] letter);
    swaf_item_t it;
    it.kind   = kind;
    it.letter = letter;
    stim_q.insert(stim_q.size(), it);
  endfunction

  // job item with the odd stray item slipped in ahead of it
  function automatic void add_job_item(logic [KIND_W-1:0] kind, logic [LETTER_W-1:0] letter);
    if ($urandom_range(99) < NOISE_PCT)
      add_item(KIND_W'($urandom_range(KIND_CLEAR, KIND_UNUSED)),
               LETTER_W'($urandom_range(0, 31)));
    add_item(kind, letter);
  endfunction

  function automatic letter_q_t shuffled(letter_q_t q);
    logic [LETTER_W-1:0] tmp;
    int                  j;
    for (int i = q.size() - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      tmp  = q[i];
      q[i] = q[j];
      q[j] = tmp;
    end
    return q;
  endfunction

  task automatic send_item(input swaf_item_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_if.valid  <= 1'b1;
    in_if.kind   <= it.kind;
    in_if.letter <= it.letter;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  initial begin
    letter_q_t           pat;
    letter_q_t           seg;
    letter_q_t           big;
    logic [LETTER_W-1:0] l;
    int                  plen;
    int                  alpha;
    bit                  big_done;

    sb = new();
    in_if.valid  <= 1'b0;
    in_if.kind   <= KIND_CLEAR;
    in_if.letter <= '0;

    // directed: empty pattern, pattern "abz" with ignored and late items
    add_item(KIND_TEXT, 5'd0);
    add_item(KIND_TEXT, 5'd25);
    add_item(KIND_CLEAR, 5'd31);
    add_item(KIND_PATTERN, 5'd0);
    add_item(KIND_PATTERN, 5'd1);
    add_item(KIND_PATTERN, 5'd25);
    add_item(KIND_PATTERN, 5'd26);
    add_item(KIND_PATTERN, 5'd31);
    add_item(KIND_TEXT, 5'd1);
    add_item(KIND_TEXT, 5'd25);
    add_item(KIND_TEXT, 5'd0);
    add_item(KIND_TEXT, 5'd31);
    add_item(KIND_UNUSED, 5'd0);
    add_item(KIND_UNUSED, 5'd31);
    add_item(KIND_PATTERN, 5'd2);
    add_item(KIND_TEXT, 5'd1);
    add_item(KIND_TEXT, 5'd2);
    add_item(KIND_TEXT, 5'd26);
    add_item(KIND_CLEAR, 5'd0);

    big_done = 1'b0;
    while (stim_q.size() < STIM_TARGET) begin
      if (!big_done && stim_q.size() >= STIM_TARGET / 8) begin
        // long narrow-alphabet pattern, then enough text to wrap the history
        big_done = 1'b1;
        big.delete();
        add_item(KIND_CLEAR, 5'd0);
        repeat (BIG_PLEN) begin
          l = LETTER_W'($urandom_range(0, 3));
          big.insert(big.size(), l);
          add_item(KIND_PATTERN, l);
        end
        repeat (BIG_REPS) begin
          big = shuffled(big);
          foreach (big[j]) add_item(KIND_TEXT, big[j]);
        end
        repeat (20) add_item(KIND_TEXT, LETTER_W'($urandom_range(0, ALPHABET - 1)));
      end
      add_item(KIND_CLEAR, LETTER_W'($urandom_range(0, 31)));
      case ($urandom_range(0, 9))
        0:       plen = 0;
        1, 2:    plen = $urandom_range(7, 40);
        default: plen = $urandom_range(1, 6);
      endcase
      // narrow alphabets make chance matches common
      alpha = $urandom_range(2, ALPHABET);
      pat.delete();
      repeat (plen) begin
        l = LETTER_W'($urandom_range(0, alpha - 1));
        pat.insert(pat.size(), l);
        add_job_item(KIND_PATTERN, l);
      end
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1)) begin
          seg = shuffled(pat);
        end else begin
          seg.delete();
          repeat ($urandom_range(1, plen + 3))
            seg.insert(seg.size(), LETTER_W'($urandom_range(0, alpha - 1)));
        end
        foreach (seg[j]) add_job_item(KIND_TEXT, seg[j]);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_q[i]) begin
      if (i < stim_q.size() / 3) begin
        tx_idle_pct = 33;
        rx_idle_pct = 60;
      end else if (i < 2 * stim_q.size() / 3) begin
        tx_idle_pct = 60;
        rx_idle_pct = 33;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_item(stim_q[i]);
    end
    in_if.valid <= 1'b0;

    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.report_leftover();

    $display("Run: %0d input items, %0d results checked, %0d of them matches.",
             sb.items_seen, sb.results_seen, sb.matches_seen);
    $display("Covered stray kinds, bad letters, an empty pattern, late pattern letters",
             " and a long window that wraps the history.");
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", sb.failures);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
